// ===== rtl/core/icaf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icaf_pkg
// Shared constants and helpers for the attitude filter core.
// ----------------------------------------------------------------------------
package icaf_pkg;

  localparam int unsigned AngleWidthDef  = 24;
  localparam int unsigned SampleWidthDef = 16;
  localparam int unsigned TiltWidth      = 16;
  localparam int unsigned TickWidth      = 16;
  localparam int unsigned CordicSteps    = 18;
  localparam int unsigned CordicShift    = 16;
  localparam int unsigned TiltLimit      = 23040;
  localparam int unsigned StepDivisor    = 125000;
  localparam int unsigned CfgAddrWidth   = 4;

  localparam logic [CfgAddrWidth-1:0] RegBlendWeight    = 4'h0;
  localparam logic [CfgAddrWidth-1:0] RegResyncInterval = 4'h4;
  localparam logic [CfgAddrWidth-1:0] RegTimerPeriod    = 4'h8;

  localparam logic [8:0]  BlendWeightRst    = 9'd251;
  localparam logic [15:0] ResyncIntervalRst = 16'd1000;
  localparam logic [15:0] TimerPeriodRst    = 16'd50000;

  // atan(2^-i) in 1/65536 degree
  function automatic logic [22:0] atan_lut(input logic [4:0] idx);
    logic [22:0] v;
    case (idx)
      5'd0:  v = 23'd2949120;
      5'd1:  v = 23'd1740967;
      5'd2:  v = 23'd919879;
      5'd3:  v = 23'd466945;
      5'd4:  v = 23'd234379;
      5'd5:  v = 23'd117304;
      5'd6:  v = 23'd58666;
      5'd7:  v = 23'd29335;
      5'd8:  v = 23'd14668;
      5'd9:  v = 23'd7334;
      5'd10: v = 23'd3667;
      5'd11: v = 23'd1833;
      5'd12: v = 23'd917;
      5'd13: v = 23'd458;
      5'd14: v = 23'd229;
      5'd15: v = 23'd115;
      5'd16: v = 23'd57;
      5'd17: v = 23'd29;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/imu_complementary_attitude_filter_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_complementary_attitude_filter_core
// Accelerometer/gyro complementary attitude filter with APB registers.
// ----------------------------------------------------------------------------
// One sample at a time. Three tilts are computed one after another by a
// shared tilt unit (a start state, SampleWidth+1 square-root steps,
// 18 CORDIC steps, a finish state). Then per axis: a multiply state, a
// shift-subtract division by 125000 (a load step plus SampleWidth+18 steps)
// and a blend state. The core accepts no new sample until the previous one
// has reached the output state; a stalled output beat holds the core in
// its output state until the previous beat is taken.
// ----------------------------------------------------------------------------
module imu_complementary_attitude_filter_core #(
  parameter int unsigned AngleWidth  = icaf_pkg::AngleWidthDef,
  parameter int unsigned SampleWidth = icaf_pkg::SampleWidthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid_i,
  output logic s_axis_tready_o,
  // accel_x, accel_y, accel_z, rate_x, rate_y, rate_z, tick_count
  input  logic [6*SampleWidth+15:0] s_axis_tdata_i,
  output logic m_axis_tvalid_o,
  input  logic m_axis_tready_i,
  // fused_x/y/z, tilt_x/y/z, integ_x/y/z
  output logic [6*AngleWidth+47:0] m_axis_tdata_o,
  input  logic psel_i,
  input  logic penable_i,
  input  logic pwrite_i,
  input  logic [icaf_pkg::CfgAddrWidth-1:0] paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic pready_o
);
  import icaf_pkg::*;

  localparam int unsigned PW   = SampleWidth + 17;
  localparam int unsigned DivW = PW + 1;
  localparam int unsigned AccW = AngleWidth + 12;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StTilt = 3'd1;
  localparam logic [2:0] StMul  = 3'd2;
  localparam logic [2:0] StDiv  = 3'd3;
  localparam logic [2:0] StAxis = 3'd4;
  localparam logic [2:0] StOut  = 3'd5;

  logic [8:0]  blend_q;
  logic [15:0] resync_int_q, period_q;
  logic [2:0]  state_q, state_d;
  logic [1:0]  axis_q, axis_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        tstart;
  logic        tdone;
  logic signed [TiltWidth-1:0] tres;

  logic [6*SampleWidth+15:0] in_q;
  logic [15:0] last_q, step_q, rcount_q;
  logic signed [AngleWidth-1:0] fused_q [3];
  logic signed [AngleWidth-1:0] integ_q [3];
  logic signed [TiltWidth-1:0]  tilt_q  [3];
  logic signed [PW-1:0]         prod_q;
  logic [DivW-1:0]              dividend_q, quot_q;
  logic [DivW:0]                drem_q;
  logic                         dneg_q;
  logic                         ovalid_q;

  logic signed [SampleWidth-1:0] ta, tb, tc, rate_sel;
  logic wr;
  logic [DivW:0] dtrial;
  logic signed [DivW:0] delta;
  logic signed [AngleWidth+1:0] isum, fsum;
  logic signed [AccW-1:0] num, rnd;
  logic [8:0] w;
  logic signed [AngleWidth-1:0] fsat, isat;
  logic [15:0] tick;

  function automatic logic signed [AngleWidth-1:0] sat(input logic signed [AccW-1:0] v);
    logic signed [AccW-1:0] hi, lo;
    hi = AccW'({1'b0, {(AngleWidth-1){1'b1}}});
    lo = -hi - AccW'(1);
    if (v > hi) return AngleWidth'(hi);
    if (v < lo) return AngleWidth'(lo);
    return AngleWidth'(v);
  endfunction

  function automatic logic signed [SampleWidth-1:0] fld(input logic [6*SampleWidth+15:0] d,
                                                      input logic [2:0] k);
    return d[k*SampleWidth +: SampleWidth];
  endfunction

  assign wr = psel_i && penable_i && pwrite_i;
  assign pready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blend_q      <= BlendWeightRst;
      resync_int_q <= ResyncIntervalRst;
      period_q     <= TimerPeriodRst;
    end else if (wr) begin
      case (paddr_i)
        RegBlendWeight:    blend_q      <= pwdata_i[8:0];
        RegResyncInterval: resync_int_q <= pwdata_i[15:0];
        RegTimerPeriod:    period_q     <= pwdata_i[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr_i)
      RegBlendWeight:    prdata_o = {23'd0, blend_q};
      RegResyncInterval: prdata_o = {16'd0, resync_int_q};
      RegTimerPeriod:    prdata_o = {16'd0, period_q};
      default:           prdata_o = '0;
    endcase
  end

  always_comb begin
    case (axis_q)
      2'd0: begin ta = fld(in_q, 3'd0); tb = fld(in_q, 3'd1); tc = fld(in_q, 3'd2); end
      2'd1: begin ta = fld(in_q, 3'd1); tb = fld(in_q, 3'd0); tc = fld(in_q, 3'd2); end
      default: begin ta = fld(in_q, 3'd2); tb = fld(in_q, 3'd0); tc = fld(in_q, 3'd1); end
    endcase
    rate_sel = fld(in_q, 3'(3 + axis_q));
  end

  icaf_tilt #(.SampleWidth(SampleWidth)) u_tilt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(tstart),
    .a_i    (ta),
    .b_i    (tb),
    .c_i    (tc),
    .done_o (tdone),
    .tilt_o (tres)
  );

  always_comb begin
    dtrial = {drem_q[DivW-1:0], dividend_q[DivW-1]};
    w = (blend_q > 9'd256) ? 9'd256 : blend_q;
    delta = dneg_q ? -$signed({1'b0, quot_q}) : $signed({1'b0, quot_q});
    isum = (AngleWidth+2)'(integ_q[axis_q]) + (AngleWidth+2)'(delta);
    fsum = (AngleWidth+2)'(fused_q[axis_q]) + (AngleWidth+2)'(delta);
    num = AccW'(fsum) * AccW'(signed'({1'b0, w}))
        + AccW'(tilt_q[axis_q]) * AccW'(signed'({1'b0, 9'd256 - w}));
    rnd = num[AccW-1] ? -((-num + AccW'(128)) >>> 8) : ((num + AccW'(128)) >>> 8);
    fsat = sat(rnd);
    isat = sat(AccW'(isum));
    tick = in_q[6*SampleWidth +: 16];
  end

  assign tstart = (state_q == StTilt) && (cnt_q == 6'd0);

  always_comb begin
    state_d = state_q;
    axis_d  = axis_q;
    cnt_d   = cnt_q;
    case (state_q)
      StIdle: if (s_axis_tvalid_i && s_axis_tready_o) begin
        state_d = StTilt; axis_d = '0; cnt_d = '0;
      end
      StTilt: begin
        cnt_d = 6'd1;
        if (tdone) begin
          cnt_d = '0;
          if (axis_q == 2'd2) begin axis_d = '0; state_d = StMul; end
          else axis_d = axis_q + 1'b1;
        end
      end
      StMul: begin state_d = StDiv; cnt_d = '0; end
      StDiv: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 6'(DivW)) state_d = StAxis;
      end
      StAxis: begin
        if (axis_q == 2'd2) begin axis_d = '0; state_d = StOut; end
        else begin axis_d = axis_q + 1'b1; state_d = StMul; end
      end
      StOut: if (!ovalid_q || m_axis_tready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  assign s_axis_tready_o = (state_q == StIdle);
  assign m_axis_tvalid_o = ovalid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      axis_q   <= '0;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
      m_axis_tdata_o <= '0;
      last_q   <= '0;
      step_q   <= '0;
      rcount_q <= '0;
      for (int k = 0; k < 3; k++) begin
        fused_q[k] <= '0;
        integ_q[k] <= '0;
      end
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
      cnt_q   <= cnt_d;
      if (state_q == StIdle && s_axis_tvalid_i && rcount_q > resync_int_q) begin
        integ_q[0] <= sat(AccW'(fused_q[0]) - AccW'(256));
        integ_q[1] <= sat(AccW'(fused_q[1]) - AccW'(256));
        rcount_q   <= '0;
      end
      if (state_q == StAxis) begin
        integ_q[axis_q] <= isat;
        fused_q[axis_q] <= fsat;
      end
      if (state_q == StOut && (!ovalid_q || m_axis_tready_i)) begin
        ovalid_q <= 1'b1;
        for (int k = 0; k < 3; k++) begin
          m_axis_tdata_o[k*AngleWidth +: AngleWidth] <= fused_q[k];
          m_axis_tdata_o[3*AngleWidth + k*16 +: 16] <= tilt_q[k];
          m_axis_tdata_o[3*AngleWidth + 48 + k*AngleWidth +: AngleWidth] <= integ_q[k];
        end
        if (tick > last_q) step_q <= tick - last_q;
        else if (tick < last_q) step_q <= period_q - last_q + tick;
        last_q <= tick;
        if (rcount_q != 16'hFFFF) rcount_q <= rcount_q + 1'b1;
      end else if (m_axis_tvalid_o && m_axis_tready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle) in_q <= s_axis_tdata_i;
    if (state_q == StTilt && tdone) tilt_q[axis_q] <= tres;
    if (state_q == StMul) begin
      prod_q     <= PW'(rate_sel) * PW'(signed'({1'b0, step_q}));
      dneg_q     <= rate_sel[SampleWidth-1];
      dividend_q <= '0;
      drem_q     <= '0;
      quot_q     <= '0;
    end
    if (state_q == StDiv) begin
      if (cnt_q == 6'd0) begin
        dividend_q <= (prod_q[PW-1] ? DivW'(-prod_q) : DivW'(prod_q)) + DivW'(StepDivisor / 2);
        drem_q <= '0;
      end else begin
        dividend_q <= dividend_q << 1;
        if (dtrial >= (DivW+1)'(StepDivisor)) begin
          drem_q <= dtrial - (DivW+1)'(StepDivisor);
          quot_q <= {quot_q[DivW-2:0], 1'b1};
        end else begin
          drem_q <= dtrial;
          quot_q <= {quot_q[DivW-2:0], 1'b0};
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result dropped");
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> state_q == StIdle) else $error("ready while busy");
  a_axis_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    axis_q != 2'd3) else $error("bad axis");
`endif

endmodule

// ===== rtl/core/icaf_tilt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icaf_tilt
// Accelerometer tilt: bit-serial integer square root, then a CORDIC
// vectoring pass with one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module icaf_tilt #(
  parameter int unsigned SampleWidth = icaf_pkg::SampleWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic signed [SampleWidth-1:0] a_i,
  input  logic signed [SampleWidth-1:0] b_i,
  input  logic signed [SampleWidth-1:0] c_i,
  output logic                          done_o,
  output logic signed [icaf_pkg::TiltWidth-1:0] tilt_o
);
  import icaf_pkg::*;

  localparam int unsigned SqW   = 2 * SampleWidth + 1;
  localparam int unsigned RootW = SampleWidth + 1;
  localparam int unsigned SqSteps = (SqW + 1) / 2;
  localparam int unsigned VecW  = RootW + CordicShift + 3;
  localparam int unsigned ZW    = 26;
  localparam int unsigned CntW  = 6;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StSqrt = 2'd1;
  localparam logic [1:0] StRot  = 2'd2;
  localparam logic [1:0] StDone = 2'd3;

  logic [1:0]              state_q, state_d;
  logic [CntW-1:0]         cnt_q, cnt_d;
  logic                    neg_q, neg_d, zero_q, zero_d;
  logic [2*SqSteps-1:0]    rad_q, rad_d;
  logic [RootW+1:0]        rem_q, rem_d;
  logic [RootW-1:0]        root_q, root_d;
  logic [SampleWidth-1:0]  mag_q, mag_d;
  logic signed [VecW-1:0]  x_q, x_d, y_q, y_d;
  logic signed [ZW-1:0]    z_q, z_d;
  logic signed [TiltWidth-1:0] tilt_q, tilt_d;

  logic signed [2*SampleWidth-1:0] bb, cc;
  logic [RootW+1:0]        trial, remsh;
  logic signed [VecW-1:0]  xs, ys;
  logic signed [ZW-1:0]    at;
  logic [ZW-1:0]           zmag;
  logic [ZW-1:0]           tmag;

  always_comb begin
    bb = b_i * b_i;
    cc = c_i * c_i;
    remsh = {rem_q[RootW-1:0], rad_q[2*SqSteps-1 -: 2]};
    trial = {root_q, 2'b01};
    xs = x_q >>> cnt_q[4:0];
    ys = y_q >>> cnt_q[4:0];
    at = ZW'(signed'({1'b0, atan_lut(cnt_q[4:0])}));
    zmag = z_q[ZW-1] ? ZW'(-z_q) : ZW'(z_q);
    tmag = (zmag + ZW'(128)) >> 8;
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    neg_d   = neg_q;
    zero_d  = zero_q;
    rad_d   = rad_q;
    rem_d   = rem_q;
    root_d  = root_q;
    mag_d   = mag_q;
    x_d     = x_q;
    y_d     = y_q;
    z_d     = z_q;
    tilt_d  = tilt_q;
    case (state_q)
      StIdle: begin
        if (start_i) begin
          rad_d   = (2*SqSteps)'(unsigned'(bb)) + (2*SqSteps)'(unsigned'(cc));
          rem_d   = '0;
          root_d  = '0;
          neg_d   = a_i[SampleWidth-1];
          zero_d  = (a_i == '0);
          mag_d   = a_i[SampleWidth-1] ? SampleWidth'(-a_i) : SampleWidth'(a_i);
          cnt_d   = '0;
          state_d = StSqrt;
        end
      end
      StSqrt: begin
        rad_d = rad_q << 2;
        if (remsh >= trial) begin
          rem_d  = remsh - trial;
          root_d = {root_q[RootW-2:0], 1'b1};
        end else begin
          rem_d  = remsh;
          root_d = {root_q[RootW-2:0], 1'b0};
        end
        if (cnt_q == CntW'(SqSteps - 1)) begin
          cnt_d   = '0;
          state_d = StRot;
          x_d = VecW'({root_d, {CordicShift{1'b0}}});
          y_d = VecW'({mag_q, {CordicShift{1'b0}}});
          z_d = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      StRot: begin
        if (!y_q[VecW-1]) begin
          x_d = x_q + ys; y_d = y_q - xs; z_d = z_q + at;
        end else begin
          x_d = x_q - ys; y_d = y_q + xs; z_d = z_q - at;
        end
        if (cnt_q == CntW'(CordicSteps - 1)) begin
          state_d = StDone;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      StDone: begin
        if (zero_q) begin
          tilt_d = '0;
        end else begin
          if (tmag > ZW'(TiltLimit)) begin
            tilt_d = TiltWidth'(TiltLimit);
          end else begin
            tilt_d = TiltWidth'(tmag);
          end
          if (z_q[ZW-1]) begin
            tilt_d = -tilt_d;
          end
          if (!neg_q) begin
            tilt_d = -tilt_d;
          end
        end
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q  <= neg_d;
    zero_q <= zero_d;
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    mag_q  <= mag_d;
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    tilt_q <= tilt_d;
  end

  assign done_o = (state_q == StDone);
  assign tilt_o = tilt_d;

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> state_q == StIdle) else $error("tilt start while busy");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("tilt done held");
  a_rot_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StRot |-> cnt_q < CntW'(CordicSteps)) else $error("cordic overrun");
`endif

endmodule
